/* design/modular_exponentiation_unit_defines.svh */
// Assertion macros shared by the modular exponentiation design files.
`ifndef MODULAR_EXPONENTIATION_UNIT_DEFINES_SVH
`define MODULAR_EXPONENTIATION_UNIT_DEFINES_SVH

// Same-cycle implication, disabled while reset is low.
`define MEXP_ASSERT_IMP(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("modexp assertion failed");

// Next-cycle implication, disabled while reset is low.
`define MEXP_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("modexp assertion failed");

`endif

/* design/mexp_pkg.sv */
// Shared constants and types of the modular exponentiation unit.
package mexp_pkg;

    localparam int WIDTH    = 16;
    localparam int MOD_W    = WIDTH + 1;
    localparam int PROD_W   = 2 * WIDTH;
    localparam int CNT_W    = $clog2(PROD_W);
    localparam int BIT_W    = $clog2(WIDTH);
    localparam int IDX_W    = 1;

    localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(PROD_W - 1);
    localparam logic [BIT_W-1:0] BIT_LAST = BIT_W'(WIDTH - 1);

    localparam logic [IDX_W-1:0] REG_EXPONENT = IDX_W'(0);
    localparam logic [IDX_W-1:0] REG_MODULUS  = IDX_W'(1);

    localparam logic [WIDTH-1:0] EXP_RESET = WIDTH'(1);
    localparam logic [WIDTH-1:0] MOD_RESET = WIDTH'(65535);

    // request to the shared modular multiplier
    typedef struct packed {
        logic             start;
        logic [WIDTH-1:0] a;
        logic [WIDTH-1:0] b;
        logic [MOD_W-1:0] modv;   // modulus, 2^WIDTH when the register holds zero
    } t_mm_req;

    typedef struct packed {
        logic             done;
        logic [WIDTH-1:0] res;
    } t_mm_rsp;

endpackage

/* design/mexp_modmul.sv */
// Sequential modular multiplier: one product, then bit-serial restoring reduction.
`include "modular_exponentiation_unit_defines.svh"

module mexp_modmul (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  mexp_pkg::t_mm_req i_req,
    output mexp_pkg::t_mm_rsp o_rsp
);
    import mexp_pkg::*;

    typedef enum logic [1:0] {
        M_IDLE = 2'b01,
        M_RED  = 2'b10
    } t_mm_state;

    t_mm_state         r_state, n_state;
    logic [CNT_W-1:0]  r_cnt;
    logic [PROD_W-1:0] r_prod;
    logic [MOD_W-1:0]  r_mod;
    logic [WIDTH-1:0]  r_rem, n_rem;
    logic              r_done;
    logic [MOD_W-1:0]  trial;

    // shift in the next product bit; remainder stays below the modulus
    always_comb begin
        trial = {r_rem, r_prod[PROD_W-1]};
        if (trial >= r_mod) begin
            n_rem = WIDTH'(trial - r_mod);
        end else begin
            n_rem = trial[WIDTH-1:0];
        end
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            M_IDLE: begin
                if (i_req.start) begin
                    n_state = M_RED;
                end
            end
            M_RED: begin
                if (r_cnt == '0) begin
                    n_state = M_IDLE;
                end
            end
            default: n_state = M_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= M_IDLE;
            r_done  <= 1'b0;
        end else begin
            r_state <= n_state;
            r_done  <= (r_state == M_RED) && (r_cnt == '0);
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_state == M_IDLE) begin
            if (i_req.start) begin
                r_prod <= PROD_W'(i_req.a) * PROD_W'(i_req.b);
                r_mod  <= i_req.modv;
                r_rem  <= '0;
                r_cnt  <= CNT_LAST;
            end
        end else begin
            r_prod <= {r_prod[PROD_W-2:0], 1'b0};
            r_rem  <= n_rem;
            r_cnt  <= r_cnt - CNT_W'(1);
        end
    end

    assign o_rsp.done = r_done;
    assign o_rsp.res  = r_rem;

    `MEXP_ASSERT_IMP(a_start_idle, i_clk, i_rst_n, i_req.start, r_state == M_IDLE)
    `MEXP_ASSERT_NEXT(a_start_red, i_clk, i_rst_n, i_req.start, (r_state == M_RED) && (r_cnt == CNT_LAST))
    `MEXP_ASSERT_IMP(a_res_reduced, i_clk, i_rst_n, r_done, {1'b0, r_rem} < r_mod)

endmodule

/* design/modular_exponentiation_unit.sv */
// Top level of the modular exponentiation unit: value^exponent mod modulus.
//
//  channel | direction | handshake           | payload
//  --------+-----------+---------------------+-------------------------------
//  input   | in        | i_valid / o_stall   | i_value
//  output  | out       | o_valid / i_stall   | o_result
//  config  | in        | i_cfg_we            | i_cfg_index, i_cfg_data
//
// An item with exponent zero skips the multiplier; any other item uses the shared modular
// multiplier (one product, 32 reduction steps) 17 + popcount(exponent) times.
// Reset (synchronous, active low) loads exponent 1 and modulus 65535 and empties the output.
// o_stall is high from the accepting edge until the result moves to the output register.
// The output register holds its item under i_stall; the next item may be accepted meanwhile.
`include "modular_exponentiation_unit_defines.svh"

module modular_exponentiation_unit (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_valid,
    output logic                        o_stall,
    input  logic [mexp_pkg::WIDTH-1:0]  i_value,
    output logic                        o_valid,
    input  logic                        i_stall,
    output logic [mexp_pkg::WIDTH-1:0]  o_result,
    input  logic                        i_cfg_we,
    input  logic [mexp_pkg::IDX_W-1:0]  i_cfg_index,
    input  logic [mexp_pkg::WIDTH-1:0]  i_cfg_data
);
    import mexp_pkg::*;

    typedef enum logic [4:0] {
        S_IDLE = 5'b00001,
        S_BASE = 5'b00010,
        S_SQR  = 5'b00100,
        S_MUL  = 5'b01000,
        S_OUT  = 5'b10000
    } t_state;

    t_state            r_state, n_state;
    logic [WIDTH-1:0]  r_exp, r_mod;
    logic [WIDTH-1:0]  r_base, n_base;
    logic [WIDTH-1:0]  r_acc, n_acc;
    logic [BIT_W-1:0]  r_bit, n_bit;
    logic              r_out_valid;
    logic [WIDTH-1:0]  r_result;
    logic [MOD_W-1:0]  mod_full;
    logic [WIDTH-1:0]  acc_init;
    logic              in_acc;
    logic              out_load;
    t_mm_req           mm_req;
    t_mm_rsp           mm_rsp;

    assign mod_full = (r_mod == '0) ? (MOD_W'(1) << WIDTH) : {1'b0, r_mod};
    assign acc_init = (r_mod == WIDTH'(1)) ? '0 : WIDTH'(1);
    assign o_stall  = (r_state != S_IDLE);
    assign in_acc   = i_valid && !o_stall;
    assign out_load = (r_state == S_OUT) && (!r_out_valid || !i_stall);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_exp <= EXP_RESET;
            r_mod <= MOD_RESET;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                REG_EXPONENT: r_exp <= i_cfg_data;
                REG_MODULUS:  r_mod <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // square-and-multiply sequencer, most significant exponent bit first
    always_comb begin
        n_state      = r_state;
        n_acc        = r_acc;
        n_base       = r_base;
        n_bit        = r_bit;
        mm_req.start = 1'b0;
        mm_req.a     = r_acc;
        mm_req.b     = r_acc;
        mm_req.modv  = mod_full;
        unique case (r_state)
            S_IDLE: begin
                if (in_acc) begin
                    if (r_exp == '0) begin
                        n_acc   = WIDTH'(1);
                        n_state = S_OUT;
                    end else begin
                        mm_req.start = 1'b1;
                        mm_req.a     = i_value;
                        mm_req.b     = WIDTH'(1);
                        n_state      = S_BASE;
                    end
                end
            end
            S_BASE: begin
                if (mm_rsp.done) begin
                    n_base       = mm_rsp.res;
                    n_acc        = acc_init;
                    n_bit        = BIT_LAST;
                    mm_req.start = 1'b1;
                    mm_req.a     = acc_init;
                    mm_req.b     = acc_init;
                    n_state      = S_SQR;
                end
            end
            S_SQR: begin
                if (mm_rsp.done) begin
                    n_acc = mm_rsp.res;
                    if (r_exp[r_bit]) begin
                        mm_req.start = 1'b1;
                        mm_req.a     = mm_rsp.res;
                        mm_req.b     = r_base;
                        n_state      = S_MUL;
                    end else if (r_bit == '0) begin
                        n_state = S_OUT;
                    end else begin
                        n_bit        = r_bit - BIT_W'(1);
                        mm_req.start = 1'b1;
                        mm_req.a     = mm_rsp.res;
                        mm_req.b     = mm_rsp.res;
                    end
                end
            end
            S_MUL: begin
                if (mm_rsp.done) begin
                    n_acc = mm_rsp.res;
                    if (r_bit == '0) begin
                        n_state = S_OUT;
                    end else begin
                        n_bit        = r_bit - BIT_W'(1);
                        mm_req.start = 1'b1;
                        mm_req.a     = mm_rsp.res;
                        mm_req.b     = mm_rsp.res;
                        n_state      = S_SQR;
                    end
                end
            end
            S_OUT: begin
                if (out_load) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (out_load) begin
                r_out_valid <= 1'b1;
            end else if (!i_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_acc  <= n_acc;
        r_base <= n_base;
        r_bit  <= n_bit;
        if (out_load) begin
            r_result <= r_acc;
        end
    end

    mexp_modmul u_modmul (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (mm_req),
        .o_rsp   (mm_rsp)
    );

    assign o_valid  = r_out_valid;
    assign o_result = r_result;

    `MEXP_ASSERT_NEXT(a_exp_zero, i_clk, i_rst_n, in_acc && (r_exp == '0), (r_state == S_OUT) && (r_acc == WIDTH'(1)))
    `MEXP_ASSERT_IMP(a_done_busy, i_clk, i_rst_n, mm_rsp.done, (r_state == S_BASE) || (r_state == S_SQR) || (r_state == S_MUL))
    `MEXP_ASSERT_IMP(a_mul_bit_set, i_clk, i_rst_n, r_state == S_MUL, r_exp[r_bit])

endmodule

/* tb/tb_top.sv */
// Self-checking testbench for the modular exponentiation unit: directed rows, then random phases.
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    import mexp_pkg::*;

    localparam int N_DIR       = 30;
    localparam int N_PHASES    = 12;
    localparam int PHASE_ITEMS = 85;
    localparam int HOLD_CYCLES = 2000;
    localparam int STALL_LIMIT = 20000;
    localparam int DRAIN_WAIT  = 1200;

    typedef enum logic {ROW_ITEM, ROW_WRITE} t_row_kind;

    typedef struct {
        t_row_kind        kind;
        logic [IDX_W-1:0] index;
        logic [WIDTH-1:0] data;
        bit               fixed;
        logic [WIDTH-1:0] want;
    } t_row;

    logic             i_clk;
    logic             i_rst_n     = 1'b0;
    logic             i_valid     = 1'b0;
    logic             o_stall;
    logic [WIDTH-1:0] i_value     = '0;
    logic             o_valid;
    logic             i_stall     = 1'b0;
    logic [WIDTH-1:0] o_result;
    logic             i_cfg_we    = 1'b0;
    logic [IDX_W-1:0] i_cfg_index = '0;
    logic [WIDTH-1:0] i_cfg_data  = '0;

    logic [WIDTH-1:0] power_q [$];
    logic [WIDTH-1:0] cur_exponent = EXP_RESET;
    logic [WIDTH-1:0] cur_modulus  = MOD_RESET;

    bit tx_gaps  = 1'b1;
    bit rx_gaps  = 1'b1;
    bit hold_req = 1'b0;

    int items_sent   = 0;
    int results_seen = 0;
    int fail_count   = 0;
    int write_count  = 0;
    int hold_count   = 0;
    int idle_cycles  = 0;

    // Rows with a typed result are read straight off the arithmetic; the rest use the predictor.
    t_row dir_rows [N_DIR] = '{
        '{ROW_ITEM,  REG_EXPONENT, 16'd0,     1'b1, 16'd0},
        '{ROW_ITEM,  REG_EXPONENT, 16'd65535, 1'b1, 16'd0},
        '{ROW_ITEM,  REG_EXPONENT, 16'd1234,  1'b1, 16'd1234},
        '{ROW_ITEM,  REG_EXPONENT, 16'd65534, 1'b1, 16'd65534},
        '{ROW_WRITE, REG_EXPONENT, 16'd0,     1'b0, 16'd0},
        '{ROW_ITEM,  REG_EXPONENT, 16'd0,     1'b1, 16'd1},
        '{ROW_ITEM,  REG_EXPONENT, 16'd65535, 1'b1, 16'd1},
        '{ROW_WRITE, REG_MODULUS,  16'd1,     1'b0, 16'd0},
        '{ROW_ITEM,  REG_EXPONENT, 16'd777,   1'b1, 16'd1},
        '{ROW_WRITE, REG_EXPONENT, 16'd65535, 1'b0, 16'd0},
        '{ROW_ITEM,  REG_EXPONENT, 16'd12345, 1'b1, 16'd0},
        '{ROW_ITEM,  REG_EXPONENT, 16'd0,     1'b1, 16'd0},
        '{ROW_WRITE, REG_MODULUS,  16'd0,     1'b0, 16'd0},
        '{ROW_WRITE, REG_EXPONENT, 16'd1,     1'b0, 16'd0},
        '{ROW_ITEM,  REG_EXPONENT, 16'd65535, 1'b1, 16'd65535},
        '{ROW_WRITE, REG_EXPONENT, 16'd2,     1'b0, 16'd0},
        '{ROW_ITEM,  REG_EXPONENT, 16'd65535, 1'b1, 16'd1},
        '{ROW_ITEM,  REG_EXPONENT, 16'd256,   1'b1, 16'd0},
        '{ROW_ITEM,  REG_EXPONENT, 16'd43690, 1'b0, 16'd0},
        '{ROW_WRITE, REG_MODULUS,  16'd3233,  1'b0, 16'd0},
        '{ROW_WRITE, REG_EXPONENT, 16'd17,    1'b0, 16'd0},
        '{ROW_ITEM,  REG_EXPONENT, 16'd65,    1'b1, 16'd2790},
        '{ROW_WRITE, REG_EXPONENT, 16'd2753,  1'b0, 16'd0},
        '{ROW_ITEM,  REG_EXPONENT, 16'd2790,  1'b1, 16'd65},
        '{ROW_ITEM,  REG_EXPONENT, 16'd40000, 1'b0, 16'd0},
        '{ROW_WRITE, REG_MODULUS,  16'd65535, 1'b0, 16'd0},
        '{ROW_WRITE, REG_EXPONENT, 16'd65535, 1'b0, 16'd0},
        '{ROW_ITEM,  REG_EXPONENT, 16'd65535, 1'b1, 16'd0},
        '{ROW_ITEM,  REG_EXPONENT, 16'd2,     1'b0, 16'd0},
        '{ROW_ITEM,  REG_EXPONENT, 16'd32768, 1'b0, 16'd0}
    };

    modular_exponentiation_unit i_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (i_valid),
        .o_stall     (o_stall),
        .i_value     (i_value),
        .o_valid     (o_valid),
        .i_stall     (i_stall),
        .o_result    (o_result),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // Right-to-left square-and-multiply; a zero modulus means 2^WIDTH.
    function automatic logic [WIDTH-1:0] expected_power(input logic [WIDTH-1:0] base,
                                                        input logic [WIDTH-1:0] expo,
                                                        input logic [WIDTH-1:0] modulus);
        longint unsigned m;
        longint unsigned b;
        longint unsigned acc;
        logic [WIDTH-1:0] e;
        if (expo == '0) begin
            return WIDTH'(1);
        end
        m   = (modulus == '0) ? (64'd1 << WIDTH) : 64'(modulus);
        b   = 64'(base) % m;
        acc = 64'd1 % m;
        e   = expo;
        while (e != '0) begin
            if (e[0]) begin
                acc = (acc * b) % m;
            end
            b = (b * b) % m;
            e = e >> 1;
        end
        return acc[WIDTH-1:0];
    endfunction

    function automatic logic [WIDTH-1:0] random_operand(input logic [WIDTH-1:0] modulus);
        case ($urandom_range(0, 9))
            0:       return '0;
            1:       return '1;
            2:       return modulus - 1'b1;
            3:       return modulus;
            4:       return WIDTH'(1);
            default: return WIDTH'($urandom_range(0, 65535));
        endcase
    endfunction

    // Registers change only with nothing in flight; the task always waits on the clock before checking.
    task automatic write_register(input logic [IDX_W-1:0] idx, input logic [WIDTH-1:0] data);
        i_valid <= 1'b0;
        do @(posedge i_clk); while (power_q.size() != 0);
        i_cfg_we    <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        case (idx)
            REG_EXPONENT: cur_exponent = data;
            REG_MODULUS:  cur_modulus  = data;
            default: ;
        endcase
        write_count++;
    endtask

    task automatic send_value(input logic [WIDTH-1:0] v, input bit fixed,
                              input logic [WIDTH-1:0] want);
        if (tx_gaps && $urandom_range(0, 3) == 0) begin
            i_valid <= 1'b0;
            repeat ($urandom_range(1, 7)) @(posedge i_clk);
        end
        i_valid <= 1'b1;
        i_value <= v;
        do @(posedge i_clk); while (o_stall !== 1'b0);
        power_q.insert(power_q.size(),
                       fixed ? want : expected_power(v, cur_exponent, cur_modulus));
        items_sent++;
    endtask

    task automatic pick_setting(input int ph, output logic [WIDTH-1:0] e,
                                output logic [WIDTH-1:0] m);
        e = WIDTH'($urandom_range(0, 65535));
        m = WIDTH'($urandom_range(2, 65535));
        case (ph)
            0:  e = WIDTH'(3);
            1:  e = WIDTH'(17);
            3:  begin
                e = '1;
                m = '1;
            end
            4:  e = '0;
            5:  m = WIDTH'(1);
            6:  m = '0;
            7:  e = WIDTH'(1);
            8:  m = WIDTH'(2);
            default: ;
        endcase
    endtask

    initial begin
        logic [WIDTH-1:0] e;
        logic [WIDTH-1:0] m;
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        foreach (dir_rows[r]) begin
            if (dir_rows[r].kind == ROW_WRITE) begin
                write_register(dir_rows[r].index, dir_rows[r].data);
            end else begin
                send_value(dir_rows[r].data, dir_rows[r].fixed, dir_rows[r].want);
            end
        end

        for (int ph = 0; ph < N_PHASES; ph++) begin
            pick_setting(ph, e, m);
            write_register(REG_EXPONENT, e);
            write_register(REG_MODULUS, m);
            tx_gaps = (ph >= 1 && ph <= 9 && ph != 5);
            rx_gaps = (ph <= 9 && ph != 7);
            // first phase: receiver holds off long enough for the block to back up
            if (ph == 0) begin
                hold_req = 1'b1;
            end
            repeat (PHASE_ITEMS) send_value(random_operand(cur_modulus), 1'b0, '0);
        end

        i_valid <= 1'b0;
        while (power_q.size() != 0) @(posedge i_clk);
        repeat (DRAIN_WAIT) @(posedge i_clk);

        $display("covered %0d items, %0d results, %0d register writes, %0d long output hold",
                 items_sent, results_seen, write_count, hold_count);
        $display("settings included exponent 0/1/max and modulus 0/1/2/max, mismatches: %0d",
                 fail_count);
        if (fail_count == 0) begin
            $display("[ OK ] regression clean");
        end else begin
            $display("[FAIL] regression broken");
        end
        $finish;
    end

    // output side back-pressure
    initial begin
        forever begin
            @(posedge i_clk);
            if (hold_req) begin
                hold_req = 1'b0;
                i_stall <= 1'b1;
                repeat (HOLD_CYCLES) @(posedge i_clk);
                i_stall <= 1'b0;
                hold_count++;
            end else if (rx_gaps && $urandom_range(0, 3) == 0) begin
                i_stall <= 1'b1;
                repeat ($urandom_range(1, 7)) @(posedge i_clk);
                i_stall <= 1'b0;
            end
        end
    end

    always @(posedge i_clk) begin
        logic [WIDTH-1:0] want;
        if (i_rst_n && o_valid === 1'b1 && i_stall == 1'b0) begin
            results_seen++;
            if (power_q.size() == 0) begin
                $display("%t: unexpected item, expected none, actual result %0d",
                         $realtime, o_result);
                fail_count++;
            end else begin
                want = power_q.pop_front();
                if (o_result !== want) begin
                    $display("%t: result mismatch, expected %0d, actual %0d",
                             $realtime, want, o_result);
                    fail_count++;
                end
            end
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if ((i_valid && o_stall === 1'b0) || (o_valid === 1'b1 && !i_stall)) begin
                idle_cycles = 0;
            end else begin
                idle_cycles++;
            end
            if (idle_cycles >= STALL_LIMIT) begin
                $display("%t: watchdog, no handshake for %0d cycles, %0d results pending",
                         $realtime, idle_cycles, power_q.size());
                $display("[FAIL] regression broken");
                $finish;
            end
        end
    end

endmodule

/* sim.f */
+incdir+design
design/mexp_pkg.sv
design/mexp_modmul.sv
design/modular_exponentiation_unit.sv
tb/tb_top.sv
